// ===== hw/rtl/mst_pkg.sv =====
// Shared constants and codes for the membership set table.
`timescale 1ns / 1ps

package mst_pkg;

   localparam int CAPACITY  = 16;
   localparam int KEY_WIDTH = 32;
   localparam int PORT_KEY_W = 32;
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_CONTAINS   = 2'd1,
      OP_REMOVE     = 2'd2,
      OP_REMOVE_ONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

endpackage

// ===== hw/rtl/membership_set_table.sv =====
// Top level of the membership set table: request control, scan, shift, pop and result register.
// A lookup, insert or remove runs a linear scan that reads one table entry per cycle from the
// entry RAM and stops at a hit or after the last held entry. Remove of a held key then shifts
// down every entry above the removed one. Remove-one reads the top entry, and on an empty table
// it goes straight to the result state.
// One request is in flight at a time; the next is accepted once the block is back in idle, which
// it reaches as rsp_valid rises, even while the previous result waits in the output register.
// Reset (synchronous, active high) empties the table and drops any pending result.
`timescale 1ns / 1ps

module membership_set_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic [mst_pkg::PORT_KEY_W-1:0] req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [mst_pkg::PORT_KEY_W-1:0] rsp_removed_value,
   output logic [mst_pkg::CNT_W-1:0]     rsp_count,
   output logic [1:0]                    rsp_status
);

   import mst_pkg::*;

   // Sequencer states, one-hot.
   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SCAN     = 6'b000010,
      ST_SHIFT    = 6'b000100,
      ST_POP      = 6'b001000,
      ST_POP_DATA = 6'b010000,
      ST_RESP     = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   op_type                op_ff, op_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;

   // Scan pipeline: the read index runs one entry ahead of the compare.
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]      cmp_idx_ff, cmp_idx_in;

   // Shift pipeline: read entry j + 1, write it to entry j in the cycle after the read.
   logic [CNT_W-1:0]      sh_rd_ff, sh_rd_in;
   logic                  sh_wr_valid_ff, sh_wr_valid_in;
   logic [IDX_W-1:0]      sh_wr_idx_ff, sh_wr_idx_in;

   // Result held between the end of the work and the output register.
   logic                  res_found_ff, res_found_in;
   logic [KEY_WIDTH-1:0]  res_removed_ff, res_removed_in;
   status_type            res_status_ff, res_status_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [PORT_KEY_W-1:0] rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   status_type            rsp_status_ff, rsp_status_in;

   // Entry RAM ports.
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   logic [KEY_WIDTH-1:0]  ram_wr_data;
   logic                  ram_rd_en;
   logic [IDX_W-1:0]      ram_rd_addr;
   logic [KEY_WIDTH-1:0]  ram_rd_data;

   logic                  req_fire;
   logic                  key_match;
   logic                  rsp_load;

   mst_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // A new request is taken only in idle; the output register can still be full then.
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // The RAM data compared in this cycle belongs to the read issued in the previous one.
   assign key_match = cmp_valid_ff && (ram_rd_data == key_ff);

   // The finished result moves into the output register once that register is free.
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      rd_idx_in      = rd_idx_ff;
      cmp_valid_in   = 1'b0;
      cmp_idx_in     = cmp_idx_ff;
      sh_rd_in       = sh_rd_ff;
      sh_wr_valid_in = 1'b0;
      sh_wr_idx_in   = sh_wr_idx_ff;
      res_found_in   = res_found_ff;
      res_removed_in = res_removed_ff;
      res_status_in  = res_status_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = count_ff[IDX_W-1:0];
      ram_wr_data    = key_ff;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = rd_idx_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in          = op_type'(req_op);
               key_in         = req_key[KEY_WIDTH-1:0];
               rd_idx_in      = '0;
               res_found_in   = 1'b0;
               res_removed_in = '0;
               res_status_in  = STATUS_OK;
               if (op_type'(req_op) == OP_REMOVE_ONE) begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_RESP;
                  end else begin
                     state_in = ST_POP;
                  end
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            if (key_match) begin
               res_found_in = 1'b1;
               if (op_ff == OP_REMOVE) begin
                  // Close the gap starting at the matched entry.
                  sh_rd_in = CNT_W'(cmp_idx_ff) + CNT_W'(1);
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_RESP;
               end
            end else if (rd_idx_ff == count_ff) begin
               // Every held entry has been compared and none matched.
               if (op_ff == OP_INSERT) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     res_status_in = STATUS_FULL;
                  end else begin
                     ram_wr_en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                  end
               end
               state_in = ST_RESP;
            end else begin
               ram_rd_en    = 1'b1;
               rd_idx_in    = rd_idx_ff + CNT_W'(1);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = rd_idx_ff[IDX_W-1:0];
            end
         end

         ST_SHIFT: begin
            if (sh_wr_valid_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = sh_wr_idx_ff;
               ram_wr_data = ram_rd_data;
            end
            if (sh_rd_ff < count_ff) begin
               ram_rd_en      = 1'b1;
               ram_rd_addr    = sh_rd_ff[IDX_W-1:0];
               sh_rd_in       = sh_rd_ff + CNT_W'(1);
               sh_wr_valid_in = 1'b1;
               sh_wr_idx_in   = sh_rd_ff[IDX_W-1:0] - IDX_W'(1);
            end else begin
               // The last pending move, if any, is written in this cycle.
               count_in = count_ff - CNT_W'(1);
               state_in = ST_RESP;
            end
         end

         ST_POP: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = count_ff[IDX_W-1:0] - IDX_W'(1);
            state_in    = ST_POP_DATA;
         end

         ST_POP_DATA: begin
            res_removed_in = ram_rd_data;
            count_in       = count_ff - CNT_W'(1);
            state_in       = ST_RESP;
         end

         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_found_in   = rsp_found_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_status_in  = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_found_in   = res_found_ff;
         rsp_removed_in = PORT_KEY_W'(res_removed_ff);
         rsp_count_in   = count_ff;
         rsp_status_in  = res_status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         cmp_valid_ff   <= 1'b0;
         sh_wr_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         cmp_valid_ff   <= cmp_valid_in;
         sh_wr_valid_ff <= sh_wr_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload and index registers.
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      key_ff         <= key_in;
      rd_idx_ff      <= rd_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      sh_rd_ff       <= sh_rd_in;
      sh_wr_idx_ff   <= sh_wr_idx_in;
      res_found_ff   <= res_found_in;
      res_removed_ff <= res_removed_in;
      res_status_ff  <= res_status_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

   // The element count never exceeds the table capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count above capacity");

   // Writes only land inside the packed region or at the append slot.
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (CNT_W'(ram_wr_addr) <= count_ff))
      else $error("entry write beyond the packed region");

   // The count changes only as a request finishes its work.
   a_count_moves_at_end: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (state_ff == ST_RESP))
      else $error("element count changed outside request completion");

   // A result only appears after the sequencer reached its result state.
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside the result state");

endmodule

// ===== hw/rtl/mst_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module mst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
